// File: design/sine_tone_generator_zero_cross_assert.svh
// Assertion macros for the sine tone generator.
// Included by the top level; no other dependencies.
`ifndef SINE_TONE_GENERATOR_ZERO_CROSS_ASSERT_SVH
`define SINE_TONE_GENERATOR_ZERO_CROSS_ASSERT_SVH

`ifndef ASSERT_OFF
`define STG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stg assertion failed");
`define STG_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stg assertion failed");
`define STG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stg assertion failed");
`else
`define STG_ASSERT(name, clk, rst_n, prop)
`define STG_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define STG_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: design/stg_pkg.sv
// Shared types, codes and constants of the sine tone generator.
// Holds the quarter-wave table entry function; no dependencies.
`timescale 1ns / 1ps

package stg_pkg;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic CFG_VOLUME    = 1'b0;
  localparam logic CFG_INIT_STEP = 1'b1;

  localparam logic [15:0] VOL_RESET = 16'd16384;
  localparam logic [15:0] VOL_FULL  = 16'd32768;
  localparam logic [31:0] STEP_RESET = 32'd39370534;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned AMP_MAX     = 64'd32767;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] new_step;
    logic        stop;
    logic        buffer_end;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
    logic               silenced;
  } result_t;

  function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned tb);
    longint unsigned x, x2, t, s, e;
    x  = (longint'(i) * HALF_PI_Q30 + ((64'd1 << tb) >> 1)) >> tb;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    e  = (s * AMP_MAX + (Q30_ONE >> 1)) >> 30;
    if (e > AMP_MAX) begin
      e = AMP_MAX;
    end
    return e[14:0];
  endfunction

endpackage

// File: design/stg_sine_rom.sv
// Quarter-wave sine table with registered read.
// Uses stg_pkg::sine_entry for the table contents.
`timescale 1ns / 1ps

module stg_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SINE_TABLE_BITS:0]   addr_i,
  output logic [14:0]                data_o
);

  localparam int TabN = 1 << SINE_TABLE_BITS;

  logic [14:0] rom [TabN+1];
  logic [14:0] data_q;

  for (genvar i = 0; i <= TabN; i++) begin : g_tab
    assign rom[i] = stg_pkg::sine_entry(i, SINE_TABLE_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: design/stg_core.sv
// Phase accumulator, step and mute state, and per-word sample logic.
// Depends on stg_pkg and stg_sine_rom.
`timescale 1ns / 1ps

module stg_core #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  stg_pkg::item_t    item_i,
  input  logic [15:0]       volume_i,
  output stg_pkg::result_t  res_o
);

  localparam int TabN = 1 << SINE_TABLE_BITS;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] active_q, active_d;
  logic [PHASE_BITS-1:0] pend_q, pend_d;
  logic                  pend_vld_q, pend_vld_d;
  logic                  prev_neg_q, prev_neg_d;
  logic                  muted_q, muted_d;

  logic [PHASE_BITS-1:0]      step_in;
  logic [PHASE_BITS-1:0]      phase_adv;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [14:0]                tab_mag;
  logic [15:0]                vol_eff;
  logic [30:0]                prod;
  logic [14:0]                mag;
  logic                       amp_neg;
  logic [15:0]                wave;
  logic                       crossing;

  assign step_in   = PHASE_BITS'(item_i.new_step);
  assign phase_adv = phase_q + active_q;
  assign vol_eff   = (volume_i > stg_pkg::VOL_FULL) ? stg_pkg::VOL_FULL : volume_i;
  assign prod      = tab_mag * vol_eff;
  assign mag       = prod[29:15];
  assign amp_neg   = phase_q[PHASE_BITS-1] && (mag != '0);
  assign wave      = amp_neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
  assign crossing  = !amp_neg && prev_neg_q;

  assign idx      = phase_d[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = phase_d[PHASE_BITS-2] ? ((SINE_TABLE_BITS+1)'(TabN) - {1'b0, idx})
                                          : {1'b0, idx};

  stg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (rom_addr),
    .data_o (tab_mag)
  );

  always_comb begin
    phase_d    = phase_q;
    active_d   = active_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    prev_neg_d = prev_neg_q;
    muted_d    = muted_q;
    res_o      = '0;
    if (take_i) begin
      unique case (item_i.mode)
        stg_pkg::MODE_TICK: begin
          res_o.valid = 1'b1;
          if (muted_q) begin
            res_o.silenced = 1'b1;
            prev_neg_d     = 1'b0;
            if (item_i.buffer_end) begin
              muted_d = 1'b0;
            end
          end else if (crossing && pend_vld_q) begin
            active_d   = pend_q;
            pend_vld_d = 1'b0;
            phase_d    = pend_q;
            prev_neg_d = 1'b0;
          end else if (crossing && item_i.stop) begin
            res_o.silenced = 1'b1;
            phase_d        = phase_adv;
            prev_neg_d     = 1'b0;
            muted_d        = !item_i.buffer_end;
          end else begin
            res_o.sample = wave;
            phase_d      = phase_adv;
            prev_neg_d   = amp_neg;
          end
        end
        stg_pkg::MODE_LOAD: begin
          pend_d     = step_in;
          pend_vld_d = 1'b1;
        end
        stg_pkg::MODE_RESTART: begin
          phase_d    = '0;
          prev_neg_d = 1'b0;
          muted_d    = 1'b0;
          if (pend_vld_q) begin
            active_d   = pend_q;
            pend_vld_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      active_q   <= PHASE_BITS'(stg_pkg::STEP_RESET);
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      prev_neg_q <= 1'b0;
      muted_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      active_q   <= active_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      prev_neg_q <= prev_neg_d;
      muted_q    <= muted_d;
    end
  end

endmodule

// File: design/sine_tone_generator_zero_cross.sv
// Top level of the sine tone generator: channels, settings and result register.
// Depends on stg_pkg, stg_core and sine_tone_generator_zero_cross_assert.svh.
//
//   channel  signals                                         direction
//   cfg      cfg_we_i cfg_addr_i cfg_wdata_i                  in, write only
//   in       in_valid_i in_ready_o mode_i new_step_i stop_i   in
//            buffer_end_i
//   out      out_valid_o out_ready_i sample_o silenced_o       out
//
// One word per cycle while in_ready_o is high; a tick word's sample is in the
// result register the cycle after acceptance. The table is read at the next phase.
// Load, restart and unused mode words give no result.
// Reset restores volume 16384, step 39370534 and phase 0; the step after reset
// is always that default, a write to initial_step does not alter it.
// in_ready_o drops only while a result waits and out_ready_i is low.
`timescale 1ns / 1ps

`include "sine_tone_generator_zero_cross_assert.svh"

module sine_tone_generator_zero_cross #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        new_step_i,
  input  logic               stop_i,
  input  logic               buffer_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               silenced_o
);

  logic [15:0]        volume_q;
  logic               take;
  stg_pkg::item_t     item;
  stg_pkg::result_t   res;
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               silenced_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign item.mode       = mode_i;
  assign item.new_step   = new_step_i;
  assign item.stop       = stop_i;
  assign item.buffer_end = buffer_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= stg_pkg::VOL_RESET;
    end else if (cfg_we_i && (cfg_addr_i == stg_pkg::CFG_VOLUME)) begin
      volume_q <= cfg_wdata_i[15:0];
    end
  end

  stg_core #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (item),
    .volume_i (volume_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      sample_q   <= res.sample;
      silenced_q <= res.silenced;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign silenced_o  = silenced_q;

  `STG_ASSERT_NEXT(a_tick_gives_word, clk_i, rst_ni,
                   take && (mode_i == stg_pkg::MODE_TICK), out_valid_o)
  `STG_ASSERT_IMPL(a_silence_is_zero, clk_i, rst_ni,
                   out_valid_o && silenced_o, sample_o == 16'sd0)
  `STG_ASSERT_IMPL(a_sample_in_range, clk_i, rst_ni,
                   out_valid_o, sample_o != 16'sh8000)

endmodule
